// ===== hw/rtl/oaht_pkg.sv =====
// Shared types and constants for the open addressing hash table.
package oaht_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_LIVE  = 2'd1;
	localparam logic [1:0] TAG_TOMB  = 2'd2;

	localparam int SIZE_BITS = 10;
	localparam int COUNT_BITS = 10;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 10'd17;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture item, start division
		logic div_step;   // one quotient bit
		logic mod_step;   // one remainder bit of quotient mod n
		logic rd;         // issue slot read at current index
		logic advance;    // move probe index
		logic wr_ins;     // write key/value/live at chosen slot
		logic wr_upd;     // write value at current slot
		logic wr_tomb;    // tombstone current slot
		logic mark_pos;   // remember tombstone position
		logic clr_step;   // clear one slot tag
		logic clr_cnt;    // zero the counts
		logic inc_cnt;
		logic dec_cnt;
		logic take_val;   // latch read value for lookup
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic div_done;
		logic mod_done;
		logic tag_empty;
		logic hit;
		logic free_slot;  // non-live
		logic have_pos;
		logic probe_last;
		logic clr_last;
	} dp_stat_t;

endpackage

// ===== hw/rtl/open_addressing_hash_table_top.sv =====
// Worst case n+1 probes per item before the result is valid.
// Clear all sweeps every slot.
// One item in flight; next input accepted from the cycle after its result transfer.
// After reset a tag clearing pass over every slot runs before input is taken.
// Top level: configuration port, size register and instances of controller and datapath.
module open_addressing_hash_table_top
	import oaht_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [0:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] value_out,
	output logic [COUNT_BITS-1:0] live_count,
	output logic [COUNT_BITS-1:0] used_count
);

	localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(CAPACITY - 1);
	localparam logic [SIZE_BITS-1:0] SIZE_LIM = SIZE_CAP[0] ? SIZE_CAP : SIZE_CAP - 1'b1;

	logic [SIZE_BITS-1:0] size_q;
	logic [SIZE_BITS-1:0] size_odd;
	logic [SIZE_BITS-1:0] size_n;
	dp_cmd_t  dcmd;
	dp_stat_t dstat;
	status_t  st;

	assign pready = 1'b1;
	assign prdata = {{(32-SIZE_BITS){1'b0}}, size_q};
	assign size_odd = size_q | SIZE_BITS'(1);
	assign size_n = (CAPACITY <= 1024 && size_odd > SIZE_LIM) ? SIZE_LIM : size_odd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= SIZE_RESET;
		else if (psel && penable && pwrite && paddr == 1'b0)
			size_q <= pwdata[SIZE_BITS-1:0];
	end

	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(cmd_t'(command)), .out_valid(out_valid), .out_ready(out_ready),
		.status(st), .cmd(dcmd), .stat(dstat)
	);

	oaht_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS))
	u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dcmd), .stat(dstat), .key(key), .value(value),
		.size_n(size_n), .value_found(value_out), .live_count(live_count),
		.used_count(used_count)
	);

	assign status = st;

endmodule

// ===== hw/rtl/oaht_datapath.sv =====
// Datapath: slot memories, division unit, probe index and counters.
module oaht_datapath
	import oaht_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [SIZE_BITS-1:0]  size_n,
	output logic [VALUE_BITS-1:0] value_found,
	output logic [COUNT_BITS-1:0] live_count,
	output logic [COUNT_BITS-1:0] used_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int IW = SIZE_BITS + 1;

	logic [KEY_BITS-1:0]   slot_key_mem [CAPACITY];
	logic [VALUE_BITS-1:0] slot_val_mem [CAPACITY];
	logic [1:0]            slot_tag_mem [CAPACITY];

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [SIZE_BITS-1:0]  n_q;
	logic [KEY_BITS-1:0]   quo_q;
	logic [SIZE_BITS-1:0]  rem_q;
	logic [SIZE_BITS-1:0]  md_q;
	logic [$clog2(KEY_BITS+1)-1:0] bit_q;
	logic [SIZE_BITS-1:0]  step_q;
	logic [SIZE_BITS-1:0]  idx_q;
	logic [SIZE_BITS-1:0]  pos_q;
	logic                  have_pos_q;
	logic                  first_q;
	logic [IW-1:0]         probes_q;
	logic [AW-1:0]         clr_q;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [1:0]            rd_tag_q;
	logic [COUNT_BITS-1:0] live_q;
	logic [COUNT_BITS-1:0] used_q;
	logic [VALUE_BITS-1:0] vfound_q;

	logic [SIZE_BITS:0] rem_sh;
	logic [SIZE_BITS:0] rem_sub;
	logic [SIZE_BITS:0] md_sh;
	logic [SIZE_BITS:0] md_sub;
	logic [SIZE_BITS:0] md_next;
	logic [SIZE_BITS:0] idx_sum;
	logic [SIZE_BITS:0] idx_red;
	logic               last_bit;
	logic               clr_end;

	assign last_bit = (bit_q == ($clog2(KEY_BITS+1))'(KEY_BITS - 1));
	assign clr_end = (clr_q == AW'(CAPACITY - 1));
	assign rem_sh = {rem_q, key_q[KEY_BITS-1-bit_q]};
	assign rem_sub = rem_sh - {1'b0, n_q};
	assign md_sh = {md_q, quo_q[KEY_BITS-1-bit_q]};
	assign md_sub = md_sh - {1'b0, n_q};
	assign md_next = md_sub[SIZE_BITS] ? md_sh : md_sub;
	assign idx_sum = {1'b0, idx_q} + {1'b0, (first_q ? step_q : SIZE_BITS'(2))};
	assign idx_red = (idx_sum >= {1'b0, n_q}) ? idx_sum - {1'b0, n_q} : idx_sum;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
			val_q <= value;
			n_q <= size_n;
			quo_q <= '0;
			rem_q <= '0;
			md_q <= '0;
			bit_q <= '0;
		end else if (cmd.div_step) begin
			if (!rem_sub[SIZE_BITS]) begin
				rem_q <= rem_sub[SIZE_BITS-1:0];
				quo_q <= {quo_q[KEY_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[SIZE_BITS-1:0];
				quo_q <= {quo_q[KEY_BITS-2:0], 1'b0};
			end
			bit_q <= last_bit ? '0 : bit_q + 1'b1;
		end else if (cmd.mod_step) begin
			md_q <= md_next[SIZE_BITS-1:0];
			bit_q <= last_bit ? '0 : bit_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			step_q <= '0;
			first_q <= 1'b0;
			probes_q <= '0;
			pos_q <= '0;
			have_pos_q <= 1'b0;
		end else if (cmd.load) begin
			have_pos_q <= 1'b0;
			probes_q <= '0;
		end else if (cmd.mod_step && last_bit) begin
			idx_q <= rem_q;
			step_q <= (md_next == '0) ? SIZE_BITS'(1) : md_next[SIZE_BITS-1:0];
			first_q <= 1'b1;
		end else begin
			if (cmd.mark_pos) begin
				pos_q <= idx_q;
				have_pos_q <= 1'b1;
			end
			if (cmd.advance) begin
				idx_q <= idx_red[SIZE_BITS-1:0];
				first_q <= 1'b0;
				probes_q <= probes_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_key_q <= slot_key_mem[AW'(idx_q)];
			rd_val_q <= slot_val_mem[AW'(idx_q)];
		end
		if (cmd.wr_ins) begin
			slot_key_mem[AW'(have_pos_q ? pos_q : idx_q)] <= key_q;
			slot_val_mem[AW'(have_pos_q ? pos_q : idx_q)] <= val_q;
		end else if (cmd.wr_upd) begin
			slot_val_mem[AW'(idx_q)] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd)
			rd_tag_q <= slot_tag_mem[AW'(idx_q)];
		if (cmd.clr_step)
			slot_tag_mem[clr_q] <= TAG_EMPTY;
		else if (cmd.wr_ins)
			slot_tag_mem[AW'(have_pos_q ? pos_q : idx_q)] <= TAG_LIVE;
		else if (cmd.wr_tomb)
			slot_tag_mem[AW'(idx_q)] <= TAG_TOMB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			live_q <= '0;
			used_q <= '0;
			vfound_q <= '0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_end ? '0 : clr_q + 1'b1;
			if (cmd.clr_cnt) begin
				live_q <= '0;
				used_q <= '0;
			end else if (cmd.inc_cnt) begin
				if (live_q != COUNT_MAX)
					live_q <= live_q + 1'b1;
				if (used_q != COUNT_MAX)
					used_q <= used_q + 1'b1;
			end else if (cmd.dec_cnt && live_q != '0) begin
				live_q <= live_q - 1'b1;
			end
			if (cmd.load)
				vfound_q <= '0;
			else if (cmd.take_val)
				vfound_q <= rd_val_q;
		end
	end

	assign stat.div_done = last_bit && cmd.div_step;
	assign stat.mod_done = last_bit && cmd.mod_step;
	assign stat.tag_empty = (rd_tag_q == TAG_EMPTY);
	assign stat.hit = (rd_tag_q == TAG_LIVE) && (rd_key_q == key_q);
	assign stat.free_slot = (rd_tag_q != TAG_LIVE);
	assign stat.have_pos = have_pos_q;
	assign stat.probe_last = (probes_q == {1'b0, n_q});
	assign stat.clr_last = clr_end;

	assign value_found = vfound_q;
	assign live_count = live_q;
	assign used_count = used_q;

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> idx_q < n_q)
		else $error("probe index out of range");
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != COUNT_MAX) |-> live_q <= used_q)
		else $error("live count above used count");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.wr_ins, cmd.wr_tomb, cmd.clr_step}) <= 1)
		else $error("conflicting tag writes");
`endif

endmodule

// ===== hw/rtl/oaht_ctrl.sv =====
// Controller state machine sequencing division, probing, writes and clearing.
module oaht_ctrl
	import oaht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cmd_t     command,
	output logic     out_valid,
	input  logic     out_ready,
	output status_t  status,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_RESET_CLR, S_IDLE, S_DIV, S_MOD, S_READ, S_CHECK, S_CLEAR, S_DONE
	} state_t;

	state_t  state_q;
	cmd_t    op_q;
	status_t status_q;
	logic    out_valid_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign status = status_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_RESET_CLR: cmd.clr_step = 1'b1;
			S_IDLE: cmd.load = in_valid && in_ready;
			S_DIV: cmd.div_step = 1'b1;
			S_MOD: begin
				cmd.mod_step = 1'b1;
			end
			S_READ: cmd.rd = 1'b1;
			S_CHECK: begin
				if (op_q == CMD_INSERT) begin
					if (stat.tag_empty) begin
						cmd.wr_ins = 1'b1;
						cmd.inc_cnt = 1'b1;
					end else if (stat.hit) begin
						cmd.wr_upd = 1'b1;
					end else begin
						cmd.mark_pos = stat.free_slot && !stat.have_pos;
						cmd.advance = !stat.probe_last;
					end
				end else if (!stat.tag_empty) begin
					if (stat.hit) begin
						cmd.take_val = (op_q == CMD_LOOKUP);
						cmd.wr_tomb = (op_q == CMD_REMOVE);
						cmd.dec_cnt = (op_q == CMD_REMOVE);
					end else begin
						cmd.advance = !stat.probe_last;
					end
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.clr_cnt = stat.clr_last;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RESET_CLR;
			op_q <= CMD_LOOKUP;
			status_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_RESET_CLR: if (stat.clr_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q <= command;
						state_q <= (command == CMD_CLEAR) ? S_CLEAR : S_DIV;
					end
				end
				S_DIV: if (stat.div_done) state_q <= S_MOD;
				S_MOD: if (stat.mod_done) state_q <= S_READ;
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (op_q == CMD_INSERT) begin
						if (stat.tag_empty || stat.hit) begin
							status_q <= ST_OK;
							state_q <= S_DONE;
						end else if (stat.probe_last) begin
							status_q <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end else if (stat.tag_empty) begin
						status_q <= ST_NOTFOUND;
						state_q <= S_DONE;
					end else if (stat.hit) begin
						status_q <= ST_OK;
						state_q <= S_DONE;
					end else if (stat.probe_last) begin
						status_q <= ST_NOTFOUND;
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_CLEAR: begin
					if (stat.clr_last) begin
						status_q <= ST_OK;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("ready outside idle");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> out_valid_q)
		else $error("result not presented");
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FULL) |-> (op_q == CMD_INSERT))
		else $error("full status on non-insert");
`endif

endmodule
